// ===== hdl/mva_pkg.sv =====
// Shared types and constants for the MIDI voice allocator.
// No dependencies; imported by mva_cmd_queue, mva_voice_engine and the top level.
`timescale 1ns / 1ps

package mva_pkg;

   localparam int VOICE_COUNT = 16;                 // 1 .. 16
   localparam int VSEL_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

   localparam int KIND_W   = 2;
   localparam int STATUS_W = 8;
   localparam int NOTE_W   = 7;
   localparam int VEL_W    = 7;
   localparam int VOICE_W  = 4;
   localparam int MASK_W   = 16;

   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = CMD_PTR_W + 1;

   localparam logic [KIND_W-1:0] KIND_MIDI = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TICK = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_NOTE_ON  = 8'h90;
   localparam logic [STATUS_W-1:0] ST_NOTE_OFF = 8'h80;

   typedef enum logic [1:0] {
      OP_NOTE_ON  = 2'd0,
      OP_NOTE_OFF = 2'd1,
      OP_TICK     = 2'd2,
      OP_DONE     = 2'd3
   } op_type;

   // one classified command between the front queue and the engine
   typedef struct packed {
      op_type              op;
      logic [NOTE_W-1:0]   note;
      logic [VEL_W-1:0]    vel;
      logic [VSEL_W-1:0]   voice;
   } cmd_type;

   // one pending message slot (valid bit kept apart)
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [NOTE_W-1:0]   note;
      logic [VEL_W-1:0]    vel;
   } pend_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } eng_state_type;

endpackage

// ===== hdl/midi_voice_allocator_core.sv =====
// Top level of the MIDI voice allocator: command queue front end plus voice engine.
// Depends on mva_pkg, mva_cmd_queue and mva_voice_engine.
`timescale 1ns / 1ps

// Usage
//   Request side is a queue: drive req_* and raise push; the item is a transfer
//   at a clock edge with push high and full low. MIDI note-on/off, buffer ticks
//   and voice-finished events share the channel (req_kind selects).
//   Result side is a queue too: while empty is low the oldest result sits on rsp_*;
//   pop high with empty low transfers it. Only ticks produce results: one per
//   pending message in voice order, or a single has_event=0 result when nothing
//   is pending; rsp_last_of_tick marks the final one.
//   Timing: a four-entry command queue sits between the front and the engine.
//   MIDI and voice-done commands are applied by the engine in its idle state. A tick
//   moves the engine to its scan state, where it emits one result per pending slot
//   (at least one), scanning one slot per cycle into its result register while
//   that register is free. A tick result passes from the command queue through
//   the engine's scan state into the result register before it can be popped.
//   If the receiver stalls, the result register holds and the scan waits; the
//   command queue keeps taking requests until it fills, then full rises.
//   Reset (synchronous, active high) clears all voices, pending slots, queue and
//   result register; the block is ready the cycle after reset drops.

module midi_voice_allocator_core
   import mva_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [STATUS_W-1:0] req_status_byte,
   input  logic [NOTE_W-1:0]   req_note_number,
   input  logic [VEL_W-1:0]    req_note_velocity,
   input  logic [VOICE_W-1:0]  req_done_voice,
   output logic                empty,
   input  logic                pop,
   output logic                rsp_has_event,
   output logic [VOICE_W-1:0]  rsp_target_voice,
   output logic [STATUS_W-1:0] rsp_out_status,
   output logic [NOTE_W-1:0]   rsp_out_note,
   output logic [VEL_W-1:0]    rsp_out_velocity,
   output logic [MASK_W-1:0]   rsp_active_mask,
   output logic                rsp_last_of_tick
);

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;

   // front: classify and buffer; ignored messages are dropped here
   mva_cmd_queue u_cmd_queue (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_kind          (req_kind),
      .req_status_byte   (req_status_byte),
      .req_note_number   (req_note_number),
      .req_note_velocity (req_note_velocity),
      .req_done_voice    (req_done_voice),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_take          (cmd_take)
   );

   // back: voice table, pending slots and tick scan
   mva_voice_engine u_voice_engine (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_take         (cmd_take),
      .empty            (empty),
      .pop              (pop),
      .rsp_has_event    (rsp_has_event),
      .rsp_target_voice (rsp_target_voice),
      .rsp_out_status   (rsp_out_status),
      .rsp_out_note     (rsp_out_note),
      .rsp_out_velocity (rsp_out_velocity),
      .rsp_active_mask  (rsp_active_mask),
      .rsp_last_of_tick (rsp_last_of_tick)
   );

endmodule

// ===== hdl/mva_cmd_queue.sv =====
// Front end: accepts request items, classifies them into commands and queues them.
// Depends on mva_pkg.
`timescale 1ns / 1ps

module mva_cmd_queue
   import mva_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [STATUS_W-1:0] req_status_byte,
   input  logic [NOTE_W-1:0]   req_note_number,
   input  logic [VEL_W-1:0]    req_note_velocity,
   input  logic [VOICE_W-1:0]  req_done_voice,
   output logic                cmd_valid,
   output cmd_type             cmd,
   input  logic                cmd_take
);

   cmd_type               q_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]  count_ff, count_in;

   cmd_type new_cmd;
   logic    keep;      // item produces work for the engine
   logic    wr_en;
   logic    rd_en;

   // classification; ignored items are taken and dropped here
   always_comb begin
      new_cmd.op    = OP_TICK;
      new_cmd.note  = req_note_number;
      new_cmd.vel   = req_note_velocity;
      new_cmd.voice = VSEL_W'(req_done_voice);
      keep          = 1'b0;
      unique case (req_kind)
         KIND_MIDI: begin
            if (req_status_byte == ST_NOTE_ON && req_note_velocity != '0) begin
               new_cmd.op = OP_NOTE_ON;
               keep       = 1'b1;
            end else if (req_status_byte == ST_NOTE_ON ||
                         req_status_byte == ST_NOTE_OFF) begin
               new_cmd.op = OP_NOTE_OFF;
               keep       = 1'b1;
            end
         end
         KIND_TICK: begin
            new_cmd.op = OP_TICK;
            keep       = 1'b1;
         end
         KIND_DONE: begin
            new_cmd.op = OP_DONE;
            keep       = ({1'b0, req_done_voice} < (VOICE_W + 1)'(VOICE_COUNT));
         end
         default: keep = 1'b0;
      endcase
   end

   assign full      = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign wr_en     = push && !full && keep;
   assign rd_en     = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== hdl/mva_voice_engine.sv =====
// Back end: voice table, pending message slots, tick scan and result register.
// Depends on mva_pkg; fed by mva_cmd_queue.
`timescale 1ns / 1ps

module mva_voice_engine
   import mva_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  cmd_type             cmd,
   output logic                cmd_take,
   output logic                empty,
   input  logic                pop,
   output logic                rsp_has_event,
   output logic [VOICE_W-1:0]  rsp_target_voice,
   output logic [STATUS_W-1:0] rsp_out_status,
   output logic [NOTE_W-1:0]   rsp_out_note,
   output logic [VEL_W-1:0]    rsp_out_velocity,
   output logic [MASK_W-1:0]   rsp_active_mask,
   output logic                rsp_last_of_tick
);

   eng_state_type state_ff, state_in;

   logic [VOICE_COUNT-1:0] active_ff, active_in;
   logic [NOTE_W-1:0]      note_ff [VOICE_COUNT];
   logic [NOTE_W-1:0]      note_in [VOICE_COUNT];
   logic [VOICE_COUNT-1:0] pvalid_ff, pvalid_in;
   pend_type               pend_ff [VOICE_COUNT];
   pend_type               pend_in [VOICE_COUNT];

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_has_ff, rsp_has_in;
   logic [VOICE_W-1:0]  rsp_voice_ff, rsp_voice_in;
   pend_type            rsp_msg_ff, rsp_msg_in;
   logic [MASK_W-1:0]   rsp_mask_ff, rsp_mask_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                   out_free;
   logic [MASK_W-1:0]      mask;
   logic                   free_found;
   logic [VSEL_W-1:0]      free_sel;
   logic                   pend_any;
   logic [VSEL_W-1:0]      pend_sel;
   logic [VOICE_COUNT-1:0] pend_onehot;
   logic                   scan_last;
   logic                   scan_emit;

   // lowest free voice and lowest pending slot
   always_comb begin
      free_found  = 1'b0;
      free_sel    = '0;
      pend_any    = 1'b0;
      pend_sel    = '0;
      pend_onehot = '0;
      mask        = '0;
      for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
         mask[v] = active_ff[v];
         if (!active_ff[v] && !pvalid_ff[v]) begin
            free_found = 1'b1;
            free_sel   = VSEL_W'(v);
         end
         if (pvalid_ff[v]) begin
            pend_any    = 1'b1;
            pend_sel    = VSEL_W'(v);
            pend_onehot = VOICE_COUNT'(1) << v;
         end
      end
      scan_last = ((pvalid_ff & ~pend_onehot) == '0);
   end

   assign out_free  = !rsp_valid_ff || pop;
   assign scan_emit = (state_ff == ST_SCAN) && out_free;

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      note_in      = note_ff;
      pvalid_in    = pvalid_ff;
      pend_in      = pend_ff;
      cmd_take     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !pop;
      rsp_has_in   = rsp_has_ff;
      rsp_voice_in = rsp_voice_ff;
      rsp_msg_in   = rsp_msg_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               unique case (cmd.op)
                  OP_NOTE_ON: begin
                     if (free_found) begin
                        active_in[free_sel]   = 1'b1;
                        note_in[free_sel]     = cmd.note;
                        pvalid_in[free_sel]   = 1'b1;
                        pend_in[free_sel]     = '{status: ST_NOTE_ON, note: cmd.note,
                                                  vel: cmd.vel};
                     end
                  end
                  OP_NOTE_OFF: begin
                     // idle voices and empty slots hold note 0 and match it too
                     for (int v = 0; v < VOICE_COUNT; v++) begin
                        if (note_ff[v] == cmd.note || pend_ff[v].note == cmd.note) begin
                           pvalid_in[v] = 1'b1;
                           pend_in[v]   = '{status: ST_NOTE_OFF, note: cmd.note,
                                            vel: cmd.vel};
                        end
                     end
                  end
                  OP_DONE: begin
                     active_in[cmd.voice] = 1'b0;
                     note_in[cmd.voice]   = '0;
                  end
                  OP_TICK: state_in = ST_SCAN;
               endcase
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mask_in  = mask;
               if (pend_any) begin
                  rsp_has_in          = 1'b1;
                  rsp_voice_in        = VOICE_W'(pend_sel);
                  rsp_msg_in          = pend_ff[pend_sel];
                  rsp_last_in         = scan_last;
                  pvalid_in[pend_sel] = 1'b0;
                  pend_in[pend_sel]   = '0;
                  if (scan_last) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  rsp_has_in   = 1'b0;
                  rsp_voice_in = '0;
                  rsp_msg_in   = '0;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         pvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int v = 0; v < VOICE_COUNT; v++) begin
            note_ff[v] <= '0;
            pend_ff[v] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         pvalid_ff    <= pvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         note_ff      <= note_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_has_ff   <= rsp_has_in;
      rsp_voice_ff <= rsp_voice_in;
      rsp_msg_ff   <= rsp_msg_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign empty            = !rsp_valid_ff;
   assign rsp_has_event    = rsp_has_ff;
   assign rsp_target_voice = rsp_voice_ff;
   assign rsp_out_status   = rsp_msg_ff.status;
   assign rsp_out_note     = rsp_msg_ff.note;
   assign rsp_out_velocity = rsp_msg_ff.vel;
   assign rsp_active_mask  = rsp_mask_ff;
   assign rsp_last_of_tick = rsp_last_ff;

   // no command is consumed while a tick scan is running
   a_no_take_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !cmd_take)
      else $error("command consumed during tick scan");

   // a result without a message only closes a tick
   a_empty_result_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_has_ff) |-> rsp_last_ff)
      else $error("empty tick result not marked last");

   // after the final result of a tick every slot is empty and the engine is idle
   a_tick_drains: assert property (@(posedge clock) disable iff (reset)
      (scan_emit && (scan_last || !pend_any)) |=> (pvalid_ff == '0 && state_ff == ST_IDLE))
      else $error("pending slots left after tick");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for midi_voice_allocator_core: directed and random
// MIDI, tick and voice-done traffic checked against a cycle-free voice table.
// Depends on mva_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module tb;
   import mva_pkg::*;

   // kind 3 has no meaning in the block; it must be swallowed without a result
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   localparam int IDLE_PCT       = 16;    // percent of cycles a side sits out
   localparam int STALL_CYCLES   = 150;   // long receiver hold-off
   localparam int STALL_AT       = 120;   // accepted requests before the hold-off
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all
   localparam int SETTLE_CYCLES  = 20;    // settling after all requests and owed results are done
   localparam int RANDOM_ITEMS   = 305;
   localparam int DRAIN_ITEM     = 200;   // random item that waits for a drained block
   localparam int CALM_FROM      = 500;   // window with no idling on either side
   localparam int CALM_TO        = 1100;

   typedef struct {
      logic [KIND_W-1:0]   kind;
      logic [STATUS_W-1:0] status;
      logic [NOTE_W-1:0]   note;
      logic [VEL_W-1:0]    vel;
      logic [VOICE_W-1:0]  voice;
      bit                  drain_first;  // hold until every tick result is back
   } req_item_type;

   typedef struct packed {
      logic                has_event;
      logic [VOICE_W-1:0]  voice;
      logic [STATUS_W-1:0] status;
      logic [NOTE_W-1:0]   note;
      logic [VEL_W-1:0]    vel;
      logic [MASK_W-1:0]   mask;
      logic                last;
   } tick_msg_type;

   // ---------------------------------------------------------------- DUT
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                push  = 1'b0;
   logic                full;
   logic [KIND_W-1:0]   req_kind          = '0;
   logic [STATUS_W-1:0] req_status_byte   = '0;
   logic [NOTE_W-1:0]   req_note_number   = '0;
   logic [VEL_W-1:0]    req_note_velocity = '0;
   logic [VOICE_W-1:0]  req_done_voice    = '0;
   logic                empty;
   logic                pop = 1'b0;
   logic                rsp_has_event;
   logic [VOICE_W-1:0]  rsp_target_voice;
   logic [STATUS_W-1:0] rsp_out_status;
   logic [NOTE_W-1:0]   rsp_out_note;
   logic [VEL_W-1:0]    rsp_out_velocity;
   logic [MASK_W-1:0]   rsp_active_mask;
   logic                rsp_last_of_tick;

   midi_voice_allocator_core uut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_kind          (req_kind),
      .req_status_byte   (req_status_byte),
      .req_note_number   (req_note_number),
      .req_note_velocity (req_note_velocity),
      .req_done_voice    (req_done_voice),
      .empty             (empty),
      .pop               (pop),
      .rsp_has_event     (rsp_has_event),
      .rsp_target_voice  (rsp_target_voice),
      .rsp_out_status    (rsp_out_status),
      .rsp_out_note      (rsp_out_note),
      .rsp_out_velocity  (rsp_out_velocity),
      .rsp_active_mask   (rsp_active_mask),
      .rsp_last_of_tick  (rsp_last_of_tick)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- voice table
   // Mirror of the allocator state; bit types so that everything starts at
   // zero, which is the reset state of the block.
   bit                  vt_active [VOICE_COUNT];
   bit [NOTE_W-1:0]     vt_note   [VOICE_COUNT];
   bit [VEL_W-1:0]      vt_vel    [VOICE_COUNT];
   bit                  slot_valid  [VOICE_COUNT];
   bit [STATUS_W-1:0]   slot_status [VOICE_COUNT];
   bit [NOTE_W-1:0]     slot_note   [VOICE_COUNT];
   bit [VEL_W-1:0]      slot_vel    [VOICE_COUNT];

   tick_msg_type  tick_msgs_due[$];   // tick results still owed by the block
   req_item_type  req_queue[$];       // requests not yet transferred

   int  cyc            = 0;
   int  accepted_count = 0;
   int  fail_count     = 0;
   int  quiet_cycles   = 0;
   int  stall_left     = 0;
   bit  stall_done     = 1'b0;
   bit  req_took       = 1'b0;
   bit  calm;
   req_item_type taken_req;

   // Apply one transferred request to the voice table and queue the tick
   // results it implies.
   task automatic update_voice_table(input req_item_type r);
      logic [STATUS_W-1:0] st;
      logic [MASK_W-1:0]   mask;
      tick_msg_type        m;
      bit                  placed;
      int                  pending;
      int                  sent;

      case (r.kind)
         KIND_MIDI: begin
            st = r.status;
            // note-on with zero velocity is a note-off in MIDI
            if (st == ST_NOTE_ON && r.vel == 0) st = ST_NOTE_OFF;
            if (st == ST_NOTE_ON) begin
               placed = 1'b0;
               for (int v = 0; v < VOICE_COUNT; v++) begin
                  if (!placed && !vt_active[v] && !slot_valid[v]) begin
                     placed         = 1'b1;
                     vt_active[v]   = 1'b1;
                     vt_note[v]     = r.note;
                     vt_vel[v]      = r.vel;
                     slot_valid[v]  = 1'b1;
                     slot_status[v] = ST_NOTE_ON;
                     slot_note[v]   = r.note;
                     slot_vel[v]    = r.vel;
                  end
               end
            end else if (st == ST_NOTE_OFF) begin
               // idle voices and empty slots carry note 0 and match too
               for (int v = 0; v < VOICE_COUNT; v++) begin
                  if (vt_note[v] == r.note || slot_note[v] == r.note) begin
                     slot_valid[v]  = 1'b1;
                     slot_status[v] = ST_NOTE_OFF;
                     slot_note[v]   = r.note;
                     slot_vel[v]    = r.vel;
                  end
               end
            end
         end
         KIND_DONE: begin
            // pending slot deliberately left alone
            if (r.voice < VOICE_COUNT) begin
               vt_active[r.voice] = 1'b0;
               vt_note[r.voice]   = '0;
               vt_vel[r.voice]    = '0;
            end
         end
         KIND_TICK: begin
            mask    = '0;
            pending = 0;
            sent    = 0;
            for (int v = 0; v < VOICE_COUNT; v++) begin
               if (vt_active[v]) mask[v] = 1'b1;
               if (slot_valid[v]) pending++;
            end
            for (int v = 0; v < VOICE_COUNT; v++) begin
               if (slot_valid[v]) begin
                  sent++;
                  m.has_event = 1'b1;
                  m.voice     = VOICE_W'(v);
                  m.status    = slot_status[v];
                  m.note      = slot_note[v];
                  m.vel       = slot_vel[v];
                  m.mask      = mask;
                  m.last      = (sent == pending);
                  tick_msgs_due.push_back(m);
                  slot_valid[v]  = 1'b0;
                  slot_status[v] = '0;
                  slot_note[v]   = '0;
                  slot_vel[v]    = '0;
               end
            end
            // empty tick still reports the mask in a single closing result
            if (pending == 0) begin
               m           = '0;
               m.mask      = mask;
               m.last      = 1'b1;
               tick_msgs_due.push_back(m);
            end
         end
         default: ;   // spare kind: no effect
      endcase
   endtask

   function automatic void add_req(input logic [KIND_W-1:0] kind,
                                   input logic [STATUS_W-1:0] status,
                                   input logic [NOTE_W-1:0] note,
                                   input logic [VEL_W-1:0] vel,
                                   input logic [VOICE_W-1:0] voice,
                                   input bit drain_first);
      req_item_type r;
      r.kind        = kind;
      r.status      = status;
      r.note        = note;
      r.vel         = vel;
      r.voice       = voice;
      r.drain_first = drain_first;
      req_queue.push_back(r);
   endfunction

   assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

   // ---------------------------------------------------------------- request side
   // Capture each transfer at the rising edge and update the voice table.
   always @(posedge clock) begin
      cyc <= cyc + 1;
      req_took <= !reset && push && !full;
      if (!reset && push && !full) begin
         taken_req.kind        = req_kind;
         taken_req.status      = req_status_byte;
         taken_req.note        = req_note_number;
         taken_req.vel         = req_note_velocity;
         taken_req.voice       = req_done_voice;
         taken_req.drain_first = 1'b0;
         update_voice_table(taken_req);
         accepted_count++;
      end
   end

   // Driver: retire the transferred request, then offer the next one unless
   // idling or waiting for the block to drain.
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (req_took) req_queue.delete(0);
         if (req_queue.size() != 0
             && !(req_queue[0].drain_first && tick_msgs_due.size() != 0)
             && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            push              <= 1'b1;
            req_kind          <= req_queue[0].kind;
            req_status_byte   <= req_queue[0].status;
            req_note_number   <= req_queue[0].note;
            req_note_velocity <= req_queue[0].vel;
            req_done_voice    <= req_queue[0].voice;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- result side
   // Receiver: one long hold-off once traffic is flowing, so the command
   // queue backs up and full rises; random idling otherwise.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left = stall_left - 1;
         pop <= 1'b0;
      end else if (!stall_done && accepted_count >= STALL_AT) begin
         stall_done = 1'b1;
         stall_left = STALL_CYCLES;
         pop <= 1'b0;
      end else begin
         pop <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Monitor: every result transfer is checked against the oldest owed result.
   always @(posedge clock) begin
      tick_msg_type got;
      tick_msg_type want;
      if (!reset && pop && !empty) begin
         got.has_event = rsp_has_event;
         got.voice     = rsp_target_voice;
         got.status    = rsp_out_status;
         got.note      = rsp_out_note;
         got.vel       = rsp_out_velocity;
         got.mask      = rsp_active_mask;
         got.last      = rsp_last_of_tick;
         if (tick_msgs_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: unexpected ev=%0d v=%0d st=%h n=%0d vel=%0d m=%h l=%0d",
                        $realtime, got.has_event, got.voice, got.status, got.note,
                        got.vel, got.mask, got.last);
         end else begin
            want = tick_msgs_due.pop_front();
            if (got !== want) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: expected ev=%0d v=%0d st=%h n=%0d vel=%0d m=%h l=%0d",
                           $realtime, want.has_event, want.voice, want.status, want.note,
                           want.vel, want.mask, want.last);
                  $display("%0t: actual   ev=%0d v=%0d st=%h n=%0d vel=%0d m=%h l=%0d",
                           $realtime, got.has_event, got.voice, got.status, got.note,
                           got.vel, got.mask, got.last);
               end
            end
         end
      end
   end

   // Watchdog: too long without any transfer on either side means a hang.
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus
   initial begin
      logic [NOTE_W-1:0] note_pool [8];
      logic [NOTE_W-1:0] n;
      logic [VEL_W-1:0]  vl;
      int                pick;

      note_pool = '{7'd0, 7'd1, 7'd60, 7'd64, 7'd67, 7'd72, 7'd100, 7'd127};

      // directed: empty tick, spare kind, status with channel bits
      add_req(KIND_TICK, 8'h00, 7'd0, 7'd0, 4'd0, 1'b0);
      add_req(KIND_SPARE, 8'hFF, 7'd127, 7'd127, 4'd15, 1'b0);
      add_req(KIND_MIDI, 8'h91, 7'd127, 7'd127, 4'd0, 1'b0);
      // fill all voices; the seventeenth note-on finds no free voice
      for (int v = 0; v <= VOICE_COUNT; v++) begin
         n  = (v == 0) ? 7'd127 : (v == 2) ? 7'd0 : NOTE_W'(v * 7);
         vl = (v == 1) ? 7'd1 : VEL_W'(127 - v);
         add_req(KIND_MIDI, ST_NOTE_ON, n, vl, 4'd0, 1'b0);
      end
      // voice-done with a message still pending, on both end voices
      add_req(KIND_DONE, 8'h00, 7'd0, 7'd0, 4'd15, 1'b0);
      add_req(KIND_DONE, 8'h00, 7'd0, 7'd0, 4'd0, 1'b0);
      add_req(KIND_TICK, 8'h00, 7'd0, 7'd0, 4'd0, 1'b0);
      // zero-velocity note-on releases voice 5; note-off 0 hits idle voices
      add_req(KIND_MIDI, ST_NOTE_ON, 7'd35, 7'd0, 4'd0, 1'b0);
      add_req(KIND_MIDI, ST_NOTE_OFF, 7'd0, 7'd127, 4'd0, 1'b0);
      add_req(KIND_TICK, 8'h00, 7'd0, 7'd0, 4'd0, 1'b0);

      // random: mostly well-formed note traffic on a small note pool so that
      // note-offs find their voices; unused fields carry junk
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(99);
         n  = ($urandom_range(3) == 0) ? NOTE_W'($urandom_range(127))
                                       : note_pool[$urandom_range(7)];
         vl = VEL_W'($urandom_range(127));
         if (pick < 40) begin
            if ($urandom_range(9) == 0) vl = '0;
            add_req(KIND_MIDI, ST_NOTE_ON, n, vl, VOICE_W'($urandom_range(15)),
                    i == DRAIN_ITEM);
         end else if (pick < 60) begin
            add_req(KIND_MIDI, ST_NOTE_OFF, n, vl, VOICE_W'($urandom_range(15)),
                    i == DRAIN_ITEM);
         end else if (pick < 77) begin
            add_req(KIND_TICK, STATUS_W'($urandom_range(255)), n, vl,
                    VOICE_W'($urandom_range(15)), i == DRAIN_ITEM);
         end else if (pick < 92) begin
            add_req(KIND_DONE, STATUS_W'($urandom_range(255)), n, vl,
                    VOICE_W'($urandom_range(15)), i == DRAIN_ITEM);
         end else begin
            // noise: any kind, any status
            add_req(KIND_W'($urandom_range(3)), STATUS_W'($urandom_range(255)),
                    NOTE_W'($urandom_range(127)), VEL_W'($urandom_range(127)),
                    VOICE_W'($urandom_range(15)), i == DRAIN_ITEM);
         end
      end
      // flush whatever is still pending
      add_req(KIND_TICK, 8'h00, 7'd0, 7'd0, 4'd0, 1'b0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (req_queue.size() != 0 || tick_msgs_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
